/* hdl/alc_pkg.sv */
// Package with sizes, request and status codes, and chain control types for the list engine.
`timescale 1ns / 1ps
`default_nettype none
package alc_pkg;
  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;

  typedef enum logic [3:0] {
    REQ_INSERT_AT    = 4'd0,
    REQ_APPEND       = 4'd1,
    REQ_SORTED       = 4'd2,
    REQ_DELETE_AT    = 4'd3,
    REQ_DELETE_FIRST = 4'd4,
    REQ_DELETE_ALL   = 4'd5,
    REQ_LOCATE       = 4'd6,
    REQ_READ         = 4'd7,
    REQ_DEDUP        = 4'd8
  } req_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_FULL     = 3'd1,
    STS_EMPTY    = 3'd2,
    STS_BADPOS   = 3'd3,
    STS_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  shift;
    logic  wr_en;
    idx_t  wr_idx;
    word_t wr_data;
  } chain_ctl_t;
endpackage
`default_nettype wire

/* hdl/alc_cell.sv */
// One list cell: holds a word, takes its right neighbor on a shift, or a direct write.
`timescale 1ns / 1ps
`default_nettype none
module alc_cell
  import alc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  shift,
  input  wire logic  wr_sel,
  input  wire word_t wr_data,
  input  wire word_t right,
  output word_t      value
);
  always_ff @(posedge clk) begin
    if (wr_sel) begin
      value <= wr_data;
    end else if (shift) begin
      value <= right;
    end
  end
endmodule
`default_nettype wire

/* hdl/alc_chain.sv */
// Row of list cells that shifts toward the head and takes a write at one selected cell.
`timescale 1ns / 1ps
`default_nettype none
module alc_chain
  import alc_pkg::*;
(
  input  wire logic       clk,
  input  wire chain_ctl_t ctl,
  output word_t           head
);
  word_t vals [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t right;
    logic  sel;
    if (i == CAPACITY - 1) begin : g_last
      assign right = vals[i];
    end else begin : g_mid
      assign right = vals[i+1];
    end
    assign sel = ctl.wr_en && (ctl.wr_idx == idx_t'(i));
    alc_cell u_cell (
      .clk     (clk),
      .shift   (ctl.shift),
      .wr_sel  (sel),
      .wr_data (ctl.wr_data),
      .right   (right),
      .value   (vals[i])
    );
  end

  assign head = vals[0];
endmodule
`default_nettype wire

/* hdl/array_list_table_engine.sv */
// Top level of the list engine: request sequencer driving the cell chain.
`timescale 1ns / 1ps
`default_nettype none
// The list lives in a row of cells that works as a queue: each pass pops every entry at the
// head once and pushes back what is kept, plus any inserted word, at the tail. A request that
// fails its checks goes straight to the result without a pass; other requests walk the chain
// one entry per cycle, pausing the walk while an inserted word is pushed. Dedup runs one pass
// per kept entry. The result is shown for one cycle with done high and cannot be held off;
// busy stays high from the accepted request until then.
module array_list_table_engine
  import alc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [3:0]            req_type,
  input  wire logic [CNT_W-1:0]      position,
  input  wire logic [DATA_WIDTH-1:0] item_value,
  output logic                       done,
  output logic [2:0]                 status,
  output logic [DATA_WIDTH-1:0]      result_value,
  output logic [CNT_W-1:0]           result_position,
  output logic [CNT_W-1:0]           removed_count,
  output logic [CNT_W-1:0]           list_length,
  output logic                       is_empty,
  output logic                       is_full
);
  state_t     state, state_next;
  req_t       req, req_next;
  cnt_t       pidx, pidx_next;
  word_t      val, val_next;
  cnt_t       fill, fill_next;
  cnt_t       q, q_next;
  cnt_t       k, k_next;
  cnt_t       j, j_next;
  word_t      key, key_next;
  logic       flag, flag_next;
  status_t    sts, sts_next;
  word_t      rval, rval_next;
  cnt_t       rpos, rpos_next;
  cnt_t       removed, removed_next;
  chain_ctl_t ctl;
  word_t      head;

  alc_chain u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .head (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    req     <= req_next;
    pidx    <= pidx_next;
    val     <= val_next;
    q       <= q_next;
    k       <= k_next;
    j       <= j_next;
    key     <= key_next;
    flag    <= flag_next;
    sts     <= sts_next;
    rval    <= rval_next;
    rpos    <= rpos_next;
    removed <= removed_next;
  end

  always_comb begin
    logic pos_ok;
    logic pop;
    logic push;
    logic match;
    word_t pdata;
    cnt_t q_pop;
    state_next   = state;
    req_next     = req;
    pidx_next    = pidx;
    val_next     = val;
    fill_next    = fill;
    q_next       = q;
    k_next       = k;
    j_next       = j;
    key_next     = key;
    flag_next    = flag;
    sts_next     = sts;
    rval_next    = rval;
    rpos_next    = rpos;
    removed_next = removed;
    pop          = 1'b0;
    push         = 1'b0;
    pdata        = head;
    match        = (head == val);
    pos_ok       = (position != '0) && (position <= fill);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          req_next     = req_t'(req_type);
          pidx_next    = position - cnt_t'(1);
          val_next     = item_value;
          q_next       = fill;
          k_next       = '0;
          j_next       = '0;
          flag_next    = 1'b0;
          sts_next     = STS_OK;
          rval_next    = '0;
          rpos_next    = '0;
          removed_next = '0;
          state_next   = ST_PASS;
          unique case (req_type)
            REQ_INSERT_AT: begin
              if (fill == cnt_t'(CAPACITY)) begin
                sts_next   = STS_FULL;
                state_next = ST_DONE;
              end else if (!pos_ok) begin
                sts_next   = STS_BADPOS;
                state_next = ST_DONE;
              end
            end
            REQ_APPEND, REQ_SORTED: begin
              if (fill == cnt_t'(CAPACITY)) begin
                sts_next   = STS_FULL;
                state_next = ST_DONE;
              end
            end
            REQ_DELETE_AT, REQ_READ: begin
              if (fill == '0) begin
                sts_next   = STS_EMPTY;
                state_next = ST_DONE;
              end else if (!pos_ok) begin
                sts_next   = STS_BADPOS;
                state_next = ST_DONE;
              end
            end
            REQ_DELETE_FIRST, REQ_DELETE_ALL, REQ_DEDUP: begin
              if (fill == '0) begin
                sts_next   = STS_EMPTY;
                state_next = ST_DONE;
              end
            end
            REQ_LOCATE: begin
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_PASS: begin
        if (k != fill) begin
          pop  = 1'b1;
          push = 1'b1;
          unique case (req)
            REQ_INSERT_AT, REQ_SORTED: begin
              if (!flag && ((req == REQ_INSERT_AT) ? (k == pidx)
                                                   : !($signed(head) < $signed(val)))) begin
                pop       = 1'b0;
                pdata     = val;
                flag_next = 1'b1;
              end
            end
            REQ_DELETE_AT: begin
              if (k == pidx) begin
                push      = 1'b0;
                rval_next = head;
              end
            end
            REQ_READ: begin
              if (k == pidx) rval_next = head;
            end
            REQ_DELETE_FIRST: begin
              if (!flag && match) begin
                push      = 1'b0;
                flag_next = 1'b1;
              end
            end
            REQ_DELETE_ALL: begin
              if (match) begin
                push         = 1'b0;
                flag_next    = 1'b1;
                removed_next = removed + cnt_t'(1);
              end
            end
            REQ_LOCATE: begin
              if (!flag && match) begin
                rpos_next = k + cnt_t'(1);
                flag_next = 1'b1;
              end
            end
            REQ_DEDUP: begin
              if (k == j) begin
                key_next = head;
              end else if ((k > j) && (head == key)) begin
                push         = 1'b0;
                removed_next = removed + cnt_t'(1);
              end
            end
            default: begin
            end
          endcase
          if (pop) k_next = k + cnt_t'(1);
        end else begin
          if ((req == REQ_INSERT_AT || req == REQ_APPEND || req == REQ_SORTED) && !flag) begin
            push  = 1'b1;
            pdata = val;
          end
          if ((req == REQ_DELETE_FIRST || req == REQ_DELETE_ALL || req == REQ_LOCATE)
              && !flag) begin
            sts_next = STS_NOTFOUND;
          end
          fill_next = push ? q + cnt_t'(1) : q;
          if ((req == REQ_DEDUP) && ((j + cnt_t'(1)) < q)) begin
            j_next = j + cnt_t'(1);
            k_next = '0;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    q_pop = pop ? q - cnt_t'(1) : q;
    if (pop && !push) q_next = q_pop;
    if (push && !pop) q_next = q + cnt_t'(1);
    ctl.shift   = pop;
    ctl.wr_en   = push;
    ctl.wr_idx  = q_pop[IDX_W-1:0];
    ctl.wr_data = pdata;
  end

  assign busy            = (state != ST_IDLE);
  assign done            = (state == ST_DONE);
  assign status          = sts;
  assign result_value    = rval;
  assign result_position = rpos;
  assign removed_count   = removed;
  assign list_length     = fill;
  assign is_empty        = (fill == '0);
  assign is_full         = (fill == cnt_t'(CAPACITY));

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("engine still busy after a result beat");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= cnt_t'(CAPACITY))
    else $error("fill count above capacity");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STS_FULL || status == STS_EMPTY || status == STS_BADPOS))
      |-> (removed_count == '0 && result_value == '0 && result_position == '0))
    else $error("failed request returned nonzero result fields");
endmodule
`default_nettype wire

/* dv/array_list_table_engine_test.sv */
// Self-checking testbench for the list engine with a driver, a monitor and a predictor.
`timescale 1ns / 1ps
module array_list_table_engine_test;
  import alc_pkg::*;

  localparam logic [3:0] REQ_SPARE_LO = 4'd9;
  localparam logic [3:0] REQ_SPARE_HI = 4'd15;
  localparam int IDLE_LIMIT = 300000;

  typedef struct {
    logic [3:0] op;
    cnt_t       pos;
    word_t      val;
    bit         hold;
  } request_t;

  typedef struct {
    logic [2:0] status;
    word_t      value;
    cnt_t       rpos;
    cnt_t       removed;
    cnt_t       length;
    logic       empty;
    logic       full;
  } answer_t;

  logic clk, rst, start, busy, done;
  logic [3:0] req_type;
  cnt_t position, result_position, removed_count, list_length;
  word_t item_value, result_value;
  logic [2:0] status;
  logic is_empty, is_full;

  array_list_table_engine uut (.*);

  request_t pending[$];
  answer_t answers_due[$];
  request_t cur;
  bit presenting;
  word_t shadow_list[CAPACITY];
  int shadow_fill;
  int burst_left, gap_left, accepted, checked, errors, idle_cycles;
  int op_seen[16];
  bit full_seen, drained;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int find_value(word_t v);
    for (int i = 0; i < shadow_fill; i++)
      if (shadow_list[i] == v) return i;
    return shadow_fill;
  endfunction

  function automatic void put_word(int idx, word_t v);
    for (int i = shadow_fill; i > idx; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[idx] = v;
    shadow_fill++;
  endfunction

  function automatic void take_word(int idx);
    for (int i = idx; i + 1 < shadow_fill; i++) shadow_list[i] = shadow_list[i+1];
    shadow_fill--;
  endfunction

  function automatic answer_t apply_request(request_t r);
    answer_t a;
    int i, w, k;
    bit full_now, empty_now, pos_ok;
    full_now = shadow_fill >= CAPACITY;
    empty_now = shadow_fill == 0;
    pos_ok = r.pos >= 1 && r.pos <= shadow_fill;
    a = '{STS_OK, '0, '0, '0, '0, 1'b0, 1'b0};
    case (r.op)
      REQ_INSERT_AT: begin
        if (full_now) a.status = STS_FULL;
        else if (!pos_ok) a.status = STS_BADPOS;
        else put_word(r.pos - 1, r.val);
      end
      REQ_APPEND: begin
        if (full_now) a.status = STS_FULL;
        else put_word(shadow_fill, r.val);
      end
      REQ_SORTED: begin
        if (full_now) a.status = STS_FULL;
        else begin
          for (i = 0; i < shadow_fill; i++)
            if (!($signed(shadow_list[i]) < $signed(r.val))) break;
          put_word(i, r.val);
        end
      end
      REQ_DELETE_AT, REQ_READ: begin
        if (empty_now) a.status = STS_EMPTY;
        else if (!pos_ok) a.status = STS_BADPOS;
        else begin
          a.value = shadow_list[r.pos - 1];
          if (r.op == REQ_DELETE_AT) take_word(r.pos - 1);
        end
      end
      REQ_DELETE_FIRST: begin
        if (empty_now) a.status = STS_EMPTY;
        else begin
          i = find_value(r.val);
          if (i >= shadow_fill) a.status = STS_NOTFOUND;
          else take_word(i);
        end
      end
      REQ_DELETE_ALL: begin
        if (empty_now) a.status = STS_EMPTY;
        else if (find_value(r.val) >= shadow_fill) a.status = STS_NOTFOUND;
        else begin
          w = 0;
          for (i = 0; i < shadow_fill; i++)
            if (shadow_list[i] != r.val) begin
              shadow_list[w] = shadow_list[i];
              w++;
            end
          a.removed = cnt_t'(shadow_fill - w);
          shadow_fill = w;
        end
      end
      REQ_LOCATE: begin
        i = find_value(r.val);
        if (i >= shadow_fill) a.status = STS_NOTFOUND;
        else a.rpos = cnt_t'(i + 1);
      end
      REQ_DEDUP: begin
        if (empty_now) a.status = STS_EMPTY;
        else begin
          w = 1;
          for (i = 1; i < shadow_fill; i++) begin
            k = 0;
            while (k < w && shadow_list[k] != shadow_list[i]) k++;
            if (k >= w) begin
              shadow_list[w] = shadow_list[i];
              w++;
            end
          end
          a.removed = cnt_t'(shadow_fill - w);
          shadow_fill = w;
        end
      end
      default: ;
    endcase
    a.length = cnt_t'(shadow_fill);
    a.empty = shadow_fill == 0;
    a.full = shadow_fill >= CAPACITY;
    return a;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH result %0d %s: got %0h expected %0h", checked, field, got, want);
  endtask

  // Driver: bursts of beats separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      presenting = 0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        answers_due.push_back(apply_request(cur));
        op_seen[cur.op]++;
        accepted++;
        if (shadow_fill >= CAPACITY) full_seen = 1;
        presenting = 0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
      if (!presenting) begin
        if (gap_left > 0) gap_left--;
        else if (pending.size() > 0 &&
                 !(pending[0].hold && answers_due.size() > 0)) begin
          cur = pending.pop_front();
          if (cur.hold) drained = 1;
          presenting = 1;
          req_type <= cur.op;
          position <= cur.pos;
          item_value <= cur.val;
        end
      end
      start <= presenting;
    end
  end

  // Monitor: results cannot be held off, so every strobe is checked.
  always @(posedge clk) begin
    answer_t e;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        errors++;
        $display("MISMATCH unexpected result, status %0d", status);
      end else begin
        e = answers_due.pop_front();
        if (status !== e.status) report_mismatch("status", status, e.status);
        if (result_value !== e.value) report_mismatch("result_value", result_value, e.value);
        if (result_position !== e.rpos)
          report_mismatch("result_position", result_position, e.rpos);
        if (removed_count !== e.removed)
          report_mismatch("removed_count", removed_count, e.removed);
        if (list_length !== e.length) report_mismatch("list_length", list_length, e.length);
        if (is_empty !== e.empty) report_mismatch("is_empty", is_empty, e.empty);
        if (is_full !== e.full) report_mismatch("is_full", is_full, e.full);
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles without a beat.", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic word_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return word_t'($signed($urandom_range(0, 8)) - 4);
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
        1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  task automatic add(logic [3:0] op, int pos, word_t val, bit hold = 0);
    request_t r;
    r.op = op;
    r.pos = cnt_t'(pos);
    r.val = val;
    r.hold = hold;
    pending.push_back(r);
  endtask

  initial begin
    word_t wmin, wmax;
    int r;
    wmin = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    wmax = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    rst = 1'b1;
    start = 1'b0;
    req_type = '0;
    position = '0;
    item_value = '0;
    errors = 0;
    accepted = 0;
    checked = 0;
    idle_cycles = 0;
    shadow_fill = 0;
    full_seen = 0;
    drained = 0;
    foreach (op_seen[i]) op_seen[i] = 0;

    // Requests on an empty list, then a sorted insert into it and more edge cases, spare codes included.
    add(REQ_DELETE_AT, 1, '0);
    add(REQ_DELETE_FIRST, 0, '0);
    add(REQ_DELETE_ALL, 0, '0);
    add(REQ_READ, 1, '0);
    add(REQ_DEDUP, 0, '0);
    add(REQ_LOCATE, 0, '0);
    add(REQ_INSERT_AT, 1, 5);
    add(REQ_SORTED, 0, wmax);
    add(REQ_SORTED, 0, wmin);
    add(REQ_APPEND, 0, '0);
    add(REQ_SORTED, 0, '1);
    add(REQ_INSERT_AT, 1, 7);
    add(REQ_INSERT_AT, 0, 7);
    add(REQ_INSERT_AT, 6, 7);
    add(REQ_READ, 5, '0);
    add(REQ_READ, 511, '0);
    add(REQ_LOCATE, 0, wmax);
    add(REQ_LOCATE, 0, 12345);
    add(REQ_DELETE_AT, 2, '0);
    add(REQ_DELETE_FIRST, 0, 12345);
    add(REQ_APPEND, 0, 7);
    add(REQ_DELETE_ALL, 0, 7);
    add(REQ_DEDUP, 0, '0);
    add(REQ_SPARE_LO, 3, 1);
    add(REQ_SPARE_HI, 0, '1);

    // Fill to capacity from a small value pool so dedup has work to do.
    for (int i = 0; i < CAPACITY; i++)
      add(REQ_APPEND, 0, word_t'($signed($urandom_range(0, 15)) - 8), i == 0);
    add(REQ_INSERT_AT, 1, 1);
    add(REQ_APPEND, 0, 1);
    add(REQ_SORTED, 0, 1);
    add(REQ_READ, CAPACITY, '0);
    add(REQ_DELETE_AT, CAPACITY, '0);
    add(REQ_APPEND, 0, wmin);
    add(REQ_DEDUP, 0, '0);
    add(REQ_DELETE_ALL, 0, wmin);

    for (int n = 0; n < 450; n++) begin
      r = $urandom_range(0, 99);
      if (r < 12) add(REQ_INSERT_AT, $urandom_range(0, 10), pick_value());
      else if (r < 27) add(REQ_APPEND, 0, pick_value());
      else if (r < 40) add(REQ_SORTED, 0, pick_value());
      else if (r < 50) add(REQ_DELETE_AT, $urandom_range(0, 10), '0);
      else if (r < 60) add(REQ_DELETE_FIRST, 0, pick_value());
      else if (r < 67) add(REQ_DELETE_ALL, 0, pick_value());
      else if (r < 77) add(REQ_LOCATE, 0, pick_value());
      else if (r < 87) add(REQ_READ, $urandom_range(0, 10), '0);
      else if (r < 92) add(REQ_DEDUP, 0, pick_value());
      else if (r < 96) add(4'($urandom_range(0, 15)), $urandom_range(0, 511), $urandom());
      else add(REQ_READ, $urandom_range(0, 511), $urandom(), n == 200);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (pending.size() == 0 && !presenting && answers_due.size() == 0);
    repeat (50) @(posedge clk);
    $display("Accepted %0d requests and checked %0d results; full list reached: %0d.",
             accepted, checked, full_seen);
    $display("Dedup %0d, delete_all %0d, sorted inserts %0d, drained pause taken: %0d.",
             op_seen[REQ_DEDUP], op_seen[REQ_DELETE_ALL], op_seen[REQ_SORTED], drained);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
